FILE: design/bitmap_page_run_allocator_macros.svh
// Assertion macros for the bitmap page run allocator checker.
// Expects aclk and aresetn in the scope where a macro is used.
`ifndef BITMAP_PAGE_RUN_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_RUN_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BPRA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bpra assertion failed");

// Next-cycle implication, disabled during reset.
`define BPRA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bpra assertion failed");

`endif

FILE: design/bpra_pkg.sv
// Shared types and constants for the bitmap page run allocator.
// No dependencies; imported by the row scan, the top level and the checker.
`timescale 1ns / 1ps

package bpra_pkg;

    localparam int WORD_W      = 8;   // pages per map row
    localparam int WORD_BITS_W = 3;   // log2 of WORD_W
    localparam int POS_W       = 21;  // page positions, covers the largest map plus one
    localparam int CNT_W       = 13;  // page counts
    localparam int PAGE_W      = 12;  // page numbers on the ports
    localparam int CFG_IDX_W   = 1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_SPACE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LIMIT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_USABLE_PAGES = 1'b1;

    localparam logic [CNT_W-1:0] LIMIT_RESET = 13'd4096;
    localparam logic [CNT_W-1:0] CNT_MAX     = 13'h1FFF;

    typedef struct packed {
        logic              cmd;
        logic [CNT_W-1:0]  page_count;
        logic [PAGE_W-1:0] start_page;
    } req_t;

    typedef struct packed {
        logic              status;
        logic [PAGE_W-1:0] run_start;
        logic [CNT_W-1:0]  used_count;
        logic [CNT_W-1:0]  free_count;
    } rsp_t;

    // Outcome of scanning one map row.
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] start;     // first page of the run found
        logic [POS_W-1:0] next_pos;  // page just past the run
        logic [CNT_W-1:0] run;       // free pages in a row at the end of the row
    } scan_res_t;

endpackage

FILE: design/bpra_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module bpra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/bpra_row_scan.sv
// Run search over one row of the page map, one page after another.
// Depends on bpra_pkg.
`timescale 1ns / 1ps

module bpra_row_scan (
    input  logic [bpra_pkg::WORD_W-1:0] row_data,
    input  logic [bpra_pkg::POS_W-1:0]  pos,
    input  logic [bpra_pkg::POS_W-1:0]  end_pos,
    input  logic [bpra_pkg::CNT_W-1:0]  need,
    input  logic [bpra_pkg::CNT_W-1:0]  run_in,
    output bpra_pkg::scan_res_t         res
);
    import bpra_pkg::*;

    logic [POS_W-1:0] page_v;
    logic [CNT_W-1:0] run_v;
    logic             found_v;
    logic [POS_W-1:0] start_v;
    logic [POS_W-1:0] next_v;

    always_comb begin
        page_v  = '0;
        run_v   = run_in;
        found_v = 1'b0;
        start_v = '0;
        next_v  = '0;
        for (int k = 0; k < WORD_W; k++) begin
            page_v = {pos[POS_W-1:WORD_BITS_W], WORD_BITS_W'(k)};
            // Pages below the entry point and at or past the end take no part.
            if (!found_v && (WORD_BITS_W'(k) >= pos[WORD_BITS_W-1:0]) && (page_v < end_pos)) begin
                if (!row_data[k]) begin
                    run_v = run_v + CNT_W'(1);
                    if (run_v == need) begin
                        found_v = 1'b1;
                        next_v  = page_v + POS_W'(1);
                        start_v = page_v + POS_W'(1) - POS_W'(need);
                    end
                end else begin
                    run_v = '0;
                end
            end
        end
        res.found    = found_v;
        res.start    = start_v;
        res.next_pos = next_v;
        res.run      = run_v;
    end

endmodule

FILE: design/bitmap_page_run_allocator.sv
// Top level of the bitmap page run allocator: sequencer, counters, map RAM.
// Depends on bpra_pkg, bpra_ram and bpra_row_scan.
`timescale 1ns / 1ps

// Usage
//   s_valid/s_ready/s_req carry one command beat: allocate a run of page_count
//   contiguous pages (next-fit from the cursor, then from page 0 up to the old
//   cursor) or free page_count pages from start_page.
//   m_valid/m_ready/m_rsp return exactly one result beat per command: status,
//   run start, used count and free count after the command.
//   cfg_wr_en/cfg_index/cfg_wdata write page_limit (index 0) or usable_pages
//   (index 1); write only while no command is in flight.
// Operation
//   The map is held 8 pages to a RAM row; one shared row-scan unit checks one
//   row per cycle. Allocate scans rows (wrapping once to page 0), then marks
//   the run's rows; a failed allocate only scans. Free clears rows; zero pages
//   skip both. The input side is busy for the whole command, then free at once.
// Reset
//   After aresetn drops, a clearing pass writes every map row to "used", one
//   row per cycle; s_ready stays low until it finishes.
// Stalls
//   A result waits in an output register while m_ready is low; the next
//   command may be taken meanwhile and holds in its last step until the
//   output register is free.
module bitmap_page_run_allocator #(
    parameter int NUM_PAGES = 4096
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  bpra_pkg::req_t                    s_req,
    output logic                              m_valid,
    input  logic                              m_ready,
    output bpra_pkg::rsp_t                    m_rsp,
    input  logic                              cfg_wr_en,
    input  logic [bpra_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bpra_pkg::CNT_W-1:0]        cfg_wdata
);
    import bpra_pkg::*;

    localparam int ROWS = (NUM_PAGES + WORD_W - 1) / WORD_W;
    localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [POS_W-1:0] NUM_POS = POS_W'(NUM_PAGES);

    typedef enum logic [6:0] {
        ST_INIT       = 7'b0000001,
        ST_IDLE       = 7'b0000010,
        ST_SCAN_ISSUE = 7'b0000100,
        ST_SCAN       = 7'b0001000,
        ST_MARK_ISSUE = 7'b0010000,
        ST_MARK       = 7'b0100000,
        ST_DONE       = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    logic [AW-1:0]    init_row_reg, init_row_next;
    logic             cmd_reg, cmd_next;
    logic [CNT_W-1:0] need_reg, need_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] end_reg, end_next;
    logic [CNT_W-1:0] run_reg, run_next;
    logic             pass_reg, pass_next;
    logic             ok_reg, ok_next;
    logic             set_reg, set_next;
    logic [POS_W-1:0] lo_reg, lo_next;
    logic [POS_W-1:0] hi_reg, hi_next;
    logic [POS_W-1:0] cursor_reg, cursor_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] limit_reg, limit_next;
    logic [CNT_W-1:0] usable_reg, usable_next;
    logic             m_valid_reg, m_valid_next;
    rsp_t             rsp_reg, rsp_next;

    logic [POS_W-1:0]  lim, second_end, next_base;
    logic [POS_W-1:0]  req_lo, req_sum, req_hi;
    logic [AW-1:0]     cur_row;
    logic [WORD_W-1:0] mark_mask;
    logic [POS_W-1:0]  mask_page;
    logic [CNT_W:0]    used_sum;
    logic [CNT_W-1:0]  used_after;
    logic              out_free;

    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr, ram_rd_addr;
    logic [WORD_W-1:0] ram_wr_data, ram_rd_data;
    scan_res_t         scan_res;

    bpra_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROWS)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    bpra_row_scan u_scan (
        .row_data (ram_rd_data),
        .pos      (pos_reg),
        .end_pos  (end_reg),
        .need     (need_reg),
        .run_in   (run_reg),
        .res      (scan_res)
    );

    // Search limit, clipped to the map size.
    assign lim        = (POS_W'(limit_reg) > NUM_POS) ? NUM_POS : POS_W'(limit_reg);
    assign second_end = (cursor_reg < lim) ? cursor_reg : lim;

    // Free range, clipped to the map end.
    assign req_lo  = POS_W'(s_req.start_page);
    assign req_sum = req_lo + POS_W'(s_req.page_count);
    assign req_hi  = (req_sum > NUM_POS) ? NUM_POS : req_sum;

    assign cur_row   = pos_reg[WORD_BITS_W +: AW];
    assign next_base = {pos_reg[POS_W-1:WORD_BITS_W] + (POS_W - WORD_BITS_W)'(1),
                        WORD_BITS_W'(0)};

    always_comb begin
        mask_page = '0;
        for (int k = 0; k < WORD_W; k++) begin
            mask_page    = {pos_reg[POS_W-1:WORD_BITS_W], WORD_BITS_W'(k)};
            mark_mask[k] = (mask_page >= lo_reg) && (mask_page < hi_reg);
        end
    end

    // Used count after the command: saturating add or floor-at-zero subtract; unchanged after a failed allocate.
    assign used_sum = {1'b0, used_reg} + {1'b0, need_reg};
    always_comb begin
        if (cmd_reg == CMD_ALLOC) begin
            if (!ok_reg) begin
                used_after = used_reg;
            end else if (used_sum[CNT_W]) begin
                used_after = CNT_MAX;
            end else begin
                used_after = used_sum[CNT_W-1:0];
            end
        end else begin
            used_after = (used_reg > need_reg) ? used_reg - need_reg : '0;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    // Map RAM ports: the clearing pass and the mark sweep write; scan and mark
    // read one row ahead so that a row arrives every cycle.
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = cur_row;
        ram_wr_data = set_reg ? (ram_rd_data | mark_mask) : (ram_rd_data & ~mark_mask);
        ram_rd_addr = cur_row;
        if (state_reg == ST_INIT) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = init_row_reg;
            ram_wr_data = '1;
        end else if (state_reg == ST_MARK) begin
            ram_wr_en   = 1'b1;
        end
        if ((state_reg == ST_SCAN) || (state_reg == ST_MARK)) begin
            ram_rd_addr = cur_row + AW'(1);
        end
    end

    always_comb begin
        state_next    = state_reg;
        init_row_next = init_row_reg;
        cmd_next      = cmd_reg;
        need_next     = need_reg;
        pos_next      = pos_reg;
        end_next      = end_reg;
        run_next      = run_reg;
        pass_next     = pass_reg;
        ok_next       = ok_reg;
        set_next      = set_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        cursor_next   = cursor_reg;
        used_next     = used_reg;
        limit_next    = limit_reg;
        usable_next   = usable_reg;
        rsp_next      = rsp_reg;
        m_valid_next  = m_valid_reg && !m_ready;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PAGE_LIMIT:   limit_next  = cfg_wdata;
                CFG_USABLE_PAGES: usable_next = cfg_wdata;
                default:          limit_next  = limit_reg;
            endcase
        end

        unique case (state_reg)
            ST_INIT: begin
                init_row_next = init_row_reg + AW'(1);
                if (init_row_reg == AW'(ROWS - 1)) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next  = s_req.cmd;
                    need_next = s_req.page_count;
                    run_next  = '0;
                    pass_next = 1'b0;
                    if (s_req.cmd == CMD_ALLOC) begin
                        set_next = 1'b1;
                        ok_next  = 1'b0;
                        priority if (s_req.page_count == '0) begin
                            state_next = ST_DONE;
                        end else if (cursor_reg < lim) begin
                            pos_next   = cursor_reg;
                            end_next   = lim;
                            state_next = ST_SCAN_ISSUE;
                        end else if (second_end != '0) begin
                            // Nothing above the cursor: go straight to the wrap pass.
                            pos_next   = '0;
                            end_next   = second_end;
                            pass_next  = 1'b1;
                            state_next = ST_SCAN_ISSUE;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end else begin
                        set_next = 1'b0;
                        ok_next  = 1'b1;
                        lo_next  = req_lo;
                        hi_next  = req_hi;
                        pos_next = req_lo;
                        state_next = (req_lo < req_hi) ? ST_MARK_ISSUE : ST_DONE;
                    end
                end
            end

            ST_SCAN_ISSUE: begin
                state_next = ST_SCAN;
            end

            ST_SCAN: begin
                priority if (scan_res.found) begin
                    ok_next    = 1'b1;
                    lo_next    = scan_res.start;
                    hi_next    = scan_res.next_pos;
                    pos_next   = scan_res.start;
                    state_next = ST_MARK_ISSUE;
                end else if (next_base < end_reg) begin
                    run_next = scan_res.run;
                    pos_next = next_base;
                end else if (!pass_reg && (second_end != '0)) begin
                    // Wrap: search again from page 0 with a fresh run.
                    run_next   = '0;
                    pos_next   = '0;
                    end_next   = second_end;
                    pass_next  = 1'b1;
                    state_next = ST_SCAN_ISSUE;
                end else begin
                    state_next = ST_DONE;
                end
            end

            ST_MARK_ISSUE: begin
                state_next = ST_MARK;
            end

            ST_MARK: begin
                pos_next = next_base;
                if (next_base >= hi_reg) begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE: begin
                // Hold here until the output register can take the result.
                if (out_free) begin
                    used_next = used_after;
                    if ((cmd_reg == CMD_ALLOC) && ok_reg) begin
                        cursor_next = hi_reg;
                    end
                    rsp_next.status     = ok_reg ? STATUS_OK : STATUS_NO_SPACE;
                    rsp_next.run_start  = ((cmd_reg == CMD_ALLOC) && ok_reg) ?
                                          lo_reg[PAGE_W-1:0] : '0;
                    rsp_next.used_count = used_after;
                    rsp_next.free_count = (usable_reg > used_after) ?
                                          usable_reg - used_after : '0;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: state_next = ST_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            init_row_reg <= '0;
            cursor_reg   <= '0;
            used_reg     <= '0;
            limit_reg    <= LIMIT_RESET;
            usable_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            init_row_reg <= init_row_next;
            cursor_reg   <= cursor_next;
            used_reg     <= used_next;
            limit_reg    <= limit_next;
            usable_reg   <= usable_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Command payload: no reset needed.
    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        need_reg <= need_next;
        pos_reg  <= pos_next;
        end_reg  <= end_next;
        run_reg  <= run_next;
        pass_reg <= pass_next;
        ok_reg   <= ok_next;
        set_reg  <= set_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        rsp_reg  <= rsp_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_rsp   = rsp_reg;

endmodule

FILE: design/bpra_checker.sv
// Port-level checker for the bitmap page run allocator, bound to the top level.
// Depends on bpra_pkg and bitmap_page_run_allocator_macros.svh.
`timescale 1ns / 1ps
`include "bitmap_page_run_allocator_macros.svh"

module bpra_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input bpra_pkg::rsp_t m_rsp
);
    import bpra_pkg::*;

    // A stalled result beat holds.
    `BPRA_ASSERT_NEXT(a_rsp_hold, m_valid && !m_ready, m_valid && $stable(m_rsp))

    // One command at a time: the input side goes busy after each accepted beat.
    `BPRA_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)

    // A failed allocation reports page 0 as its start.
    `BPRA_ASSERT_NOW(a_fail_start_zero, m_valid && (m_rsp.status == STATUS_NO_SPACE),
                     m_rsp.run_start == '0)

    // Out of reset: map clearing pass running, no result pending.
    `BPRA_ASSERT_NOW(a_reset_quiet, $past(!aresetn), !m_valid && !s_ready)

endmodule

bind bitmap_page_run_allocator bpra_checker u_bpra_checker (.*);
